@@ rtl/clbq_pkg.sv @@
// Shared types and constants for the credit load balancer queue.
// No dependencies; used by every other file of the block.
package clbq_pkg;

  localparam int QUEUE_DEPTH     = 128;
  localparam int SERVER_COUNT    = 3;
  localparam int INITIAL_CREDITS = 5;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SIDX_W = (SERVER_COUNT > 1) ? $clog2(SERVER_COUNT) : 1;

  localparam logic [15:0] SERVICE_PORT_RST  = 16'd20000;
  localparam logic [23:0] SUBNET_PREFIX_RST = {8'd172, 8'd17, 8'd0};

  localparam int PADDR_W = 3;

  typedef enum logic {
    REG_SERVICE_PORT  = 1'b0,
    REG_SUBNET_PREFIX = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_PASS = 2'd0,
    ACT_DROP = 2'd1,
    ACT_TX   = 2'd2
  } action_t;

  typedef struct packed {
    logic        is_tcp_ipv4;
    logic [15:0] dst_port;
    logic [31:0] src_addr;
    logic [31:0] payload;
  } in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  dest_host;
    logic [31:0] payload_out;
    logic        from_queue;
  } out_t;

  typedef struct packed {
    logic [15:0] service_port;
    logic [23:0] subnet_prefix;
  } cfg_t;

  typedef struct packed {
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [31:0]      wr_data;
  } mem_req_t;

endpackage

@@ rtl/clbq_regs.sv @@
// Configuration registers behind the APB-style port.
// Depends on clbq_pkg.
module clbq_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [clbq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output clbq_pkg::cfg_t               cfg
);

  logic [15:0] service_port_r;
  logic [23:0] subnet_prefix_r;
  logic        wr_en;
  logic        sel_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  // registers sit on 4-byte steps; byte offset bits are ignored
  assign sel_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      service_port_r  <= clbq_pkg::SERVICE_PORT_RST;
      subnet_prefix_r <= clbq_pkg::SUBNET_PREFIX_RST;
    end else if (wr_en) begin
      case (sel_idx)
        clbq_pkg::REG_SERVICE_PORT:  service_port_r  <= pwdata[15:0];
        clbq_pkg::REG_SUBNET_PREFIX: subnet_prefix_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel_idx)
      clbq_pkg::REG_SERVICE_PORT:  prdata = {16'd0, service_port_r};
      clbq_pkg::REG_SUBNET_PREFIX: prdata = {8'd0, subnet_prefix_r};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg.service_port  = service_port_r;
  assign cfg.subnet_prefix = subnet_prefix_r;

endmodule

@@ rtl/clbq_store.sv @@
// Request FIFO storage: one write and one registered read port.
// Depends on clbq_pkg.
module clbq_store (
  input  logic                 clk,
  input  clbq_pkg::mem_req_t   req,
  output logic [31:0]          rd_data
);

  logic [31:0] mem [clbq_pkg::QUEUE_DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/clbq_ctrl.sv @@
// Verdict logic: server credits, FIFO pointers and the result register.
// Depends on clbq_pkg; drives clbq_store.
module clbq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clbq_pkg::cfg_t       cfg,
  input  logic                 start,
  input  clbq_pkg::in_t        in_data,
  output logic                 busy,
  output logic                 out_valid,
  output clbq_pkg::out_t       out_data,
  output clbq_pkg::mem_req_t   mem_req,
  input  logic [31:0]          mem_rd_data
);

  logic                        busy_r;
  clbq_pkg::in_t               item_r;
  logic [7:0]                  credit_r [clbq_pkg::SERVER_COUNT];
  logic [7:0]                  credit_nxt [clbq_pkg::SERVER_COUNT];
  logic [clbq_pkg::PTR_W-1:0]  head_r, head_nxt;
  logic [clbq_pkg::PTR_W-1:0]  tail_r, tail_nxt;
  logic [clbq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                        out_valid_r;
  clbq_pkg::out_t              out_r, out_nxt;

  logic                        accept;
  logic                        svc_hit;
  logic                        from_server;
  logic [7:0]                  host;
  logic [clbq_pkg::SIDX_W-1:0] srv_idx;
  logic                        pick_found;
  logic [clbq_pkg::SIDX_W-1:0] pick_idx;
  logic                        q_empty;
  logic                        q_full;
  logic                        enq;

  assign accept  = start & ~busy_r;
  assign busy    = busy_r;
  assign host    = item_r.src_addr[7:0];
  assign srv_idx = clbq_pkg::SIDX_W'(host - 8'd1);
  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == clbq_pkg::CNT_W'(clbq_pkg::QUEUE_DEPTH));

  assign svc_hit = item_r.is_tcp_ipv4 & (item_r.dst_port == cfg.service_port);
  assign from_server = (item_r.src_addr[31:8] == cfg.subnet_prefix) && (host >= 8'd1)
                       && (host <= 8'(clbq_pkg::SERVER_COUNT));

  // lowest-numbered server holding credit
  always_comb begin
    pick_found = 1'b0;
    pick_idx   = '0;
    for (int i = 0; i < clbq_pkg::SERVER_COUNT; i++) begin
      if (!pick_found && credit_r[i] != 8'd0) begin
        pick_found = 1'b1;
        pick_idx   = clbq_pkg::SIDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < clbq_pkg::SERVER_COUNT; i++) begin
      credit_nxt[i] = credit_r[i];
    end
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    enq       = 1'b0;
    out_nxt   = '0;
    out_nxt.action = clbq_pkg::ACT_PASS;

    if (busy_r && svc_hit) begin
      if (from_server) begin
        if (!q_empty) begin
          out_nxt.action      = clbq_pkg::ACT_TX;
          out_nxt.dest_host   = host;
          out_nxt.payload_out = mem_rd_data;
          out_nxt.from_queue  = 1'b1;
          head_nxt  = (head_r == clbq_pkg::PTR_W'(clbq_pkg::QUEUE_DEPTH - 1)) ? '0
                      : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end else begin
          out_nxt.action = clbq_pkg::ACT_DROP;
          if (credit_r[srv_idx] != 8'hFF) begin
            credit_nxt[srv_idx] = credit_r[srv_idx] + 8'd1;
          end
        end
      end else if (pick_found) begin
        out_nxt.action      = clbq_pkg::ACT_TX;
        out_nxt.dest_host   = 8'(pick_idx) + 8'd1;
        out_nxt.payload_out = item_r.payload;
        credit_nxt[pick_idx] = credit_r[pick_idx] - 8'd1;
      end else if (!q_full) begin
        out_nxt.action = clbq_pkg::ACT_DROP;
        enq       = 1'b1;
        tail_nxt  = (tail_r == clbq_pkg::PTR_W'(clbq_pkg::QUEUE_DEPTH - 1)) ? '0
                    : tail_r + 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // head word is fetched as the item is taken, so it is ready for the verdict cycle
  assign mem_req.rd_en   = accept;
  assign mem_req.rd_addr = head_r;
  assign mem_req.wr_en   = enq;
  assign mem_req.wr_addr = tail_r;
  assign mem_req.wr_data = item_r.payload;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      for (int i = 0; i < clbq_pkg::SERVER_COUNT; i++) begin
        credit_r[i] <= 8'(clbq_pkg::INITIAL_CREDITS);
      end
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      for (int i = 0; i < clbq_pkg::SERVER_COUNT; i++) begin
        credit_r[i] <= credit_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (busy_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/credit_load_balancer_queue_unit.sv @@
// Credit load balancer with request FIFO: one verdict word per packet.
// An item is taken on start while busy is low; busy then stays high for one cycle, so no
// new item is taken while the last one is being judged. The verdict appears on out_data
// with the out_valid strobe, registered after busy, and holds for one cycle only; the
// receiver cannot stall it. The verdict uses the registered read of the FIFO head
// word from the request store. Depends on clbq_pkg, clbq_regs, clbq_store, clbq_ctrl.
module credit_load_balancer_queue_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  clbq_pkg::in_t                in_data,
  output logic                         out_valid,
  output clbq_pkg::out_t               out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [clbq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  clbq_pkg::cfg_t     cfg;
  clbq_pkg::mem_req_t mem_req;
  logic [31:0]        mem_rd_data;

  clbq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clbq_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  clbq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .start       (start),
    .in_data     (in_data),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

endmodule
